### sv/can_packet_reassembler_core_defines.svh
// ----------------------------------------------------------------------------
// can packet reassembler assertion macros
// concurrent check helpers that sample on clk and stay quiet during rst
// ----------------------------------------------------------------------------
`ifndef CAN_PACKET_REASSEMBLER_CORE_DEFINES_SVH
`define CAN_PACKET_REASSEMBLER_CORE_DEFINES_SVH

// same-cycle implication
`define CPR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpr check failed");

// next-cycle implication
`define CPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpr check failed");

`endif

### sv/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// shared sizes, codes, crc helper and controller/datapath bundles
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int MAX_PACKET = 512;

  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_PACKET + 1);
  localparam int MEM_DEPTH = NUM_SLOTS * MAX_PACKET;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // frame kinds
  localparam logic [1:0] CMD_FILL_SHORT = 2'd0;
  localparam logic [1:0] CMD_FILL_LONG  = 2'd1;
  localparam logic [1:0] CMD_PROCESS    = 2'd2;
  localparam logic [1:0] CMD_SHORT_BUF  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_DATA          = 3'd0;
  localparam logic [2:0] ST_CRC_ERR       = 3'd1;
  localparam logic [2:0] ST_NO_SLOT       = 3'd2;
  localparam logic [2:0] ST_NOT_DELIVERED = 3'd3;
  localparam logic [2:0] ST_BAD_MODE      = 3'd4;

  // send modes
  localparam logic [7:0] MODE_SEND  = 8'd1;
  localparam logic [7:0] MODE_LIMIT = 8'd3;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // one byte of crc-16/xmodem, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic fill_wr;
    logic fill_commit;
    logic rd_clear;
    logic rd_run;
    logic rd_chunk;
    logic slot_free;
    logic out_load;
    logic out_chunk;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       found;
    logic       fits;
    logic       short_ok;
    logic       fill_done;
    logic       crc_done;
    logic       deliver;
    logic       chunk_ready;
    logic       last_chunk;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### sv/cpr_if.sv
// ----------------------------------------------------------------------------
// cpr channel interfaces
// frame input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface can_frame_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  target_id;
  logic [3:0]  frame_len;
  logic [63:0] payload;

  modport source (output valid, cmd, target_id, frame_len, payload, input ready);
  modport sink   (input valid, cmd, target_id, frame_len, payload, output ready);
endinterface

interface can_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  source_id;
  logic [9:0]  packet_len;
  logic [63:0] chunk;
  logic [3:0]  chunk_bytes;
  logic        last;

  modport source (output valid, status, source_id, packet_len, chunk, chunk_bytes, last,
                  input ready);
  modport sink   (input valid, status, source_id, packet_len, chunk, chunk_bytes, last,
                  output ready);
endinterface

`default_nettype wire

### sv/can_packet_reassembler_core.sv
// ----------------------------------------------------------------------------
// can_packet_reassembler_core
// can multi-frame reassembly into slots with crc-16/xmodem check and delivery
// ----------------------------------------------------------------------------
// One frame is worked on at a time; the frame port is ready only when the
// sequencer is idle, while the last result may still sit in the output
// register. A fill frame is captured and looked up, then writes its payload
// bytes into the slot and commits the count. A short buffer frame is captured
// and looked up, then gives its result if accepted. A process frame is captured
// and looked up, then makes a crc pass over the packet, since the packet memory
// has a single read port read one byte per cycle, and then gives its result; a
// delivered packet is then read again through that port word by word, plus any
// wait on the result side. The slot memory needs no clearing after reset.
`default_nettype none

module can_packet_reassembler_core import cpr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  can_frame_if.sink       frame,
  can_result_if.source    result
);

  dp_cmd_t  ctl;
  dp_stat_t st;

  // sequencer
  cpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frame.valid),
    .in_ready (frame.ready),
    .st       (st),
    .ctl      (ctl)
  );

  // storage and datapath
  cpr_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .ctl             (ctl),
    .st              (st),
    .in_cmd          (frame.cmd),
    .in_target_id    (frame.target_id),
    .in_frame_len    (frame.frame_len),
    .in_payload      (frame.payload),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_status      (result.status),
    .out_source_id   (result.source_id),
    .out_packet_len  (result.packet_len),
    .out_chunk       (result.chunk),
    .out_chunk_bytes (result.chunk_bytes),
    .out_last        (result.last)
  );

endmodule

`default_nettype wire

### sv/cpr_datapath.sv
// ----------------------------------------------------------------------------
// cpr_datapath
// slot table, packet byte memory, crc engine, chunk builder and result register
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_datapath import cpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire dp_cmd_t     ctl,
  output dp_stat_t         st,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_target_id,
  input  wire logic [3:0]  in_frame_len,
  input  wire logic [63:0] in_payload,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_source_id,
  output logic [9:0]       out_packet_len,
  output logic [63:0]      out_chunk,
  output logic [3:0]       out_chunk_bytes,
  output logic             out_last
);

  logic [7:0]  own_id;
  logic [1:0]  cmd_r;
  logic [7:0]  tgt_r;
  logic [3:0]  len_r;
  logic [63:0] pl_r;

  logic              streaming [NUM_SLOTS];
  logic [CNT_W-1:0]  count     [NUM_SLOTS];

  logic [SLOT_W-1:0] sel_r;
  logic              found_r;
  logic [CNT_W-1:0]  plen_r;
  logic [2:0]        fidx;

  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  got;
  logic [CNT_W-1:0]  pos;
  logic [15:0]       crc;
  logic [63:0]       chunk_r;
  logic              rd_vld;
  logic [7:0]        rd_data;

  logic [7:0] mem [MEM_DEPTH];

  logic [7:0]        pb [8];
  logic              is_long;
  logic              is_proc;
  logic [3:0]        hdr;
  logic [2:0]        n;
  logic [15:0]       off16;
  logic [15:0]       rlen;
  logic [15:0]       rcrc;
  logic              key_stream;
  logic [15:0]       key_cnt;
  logic              found_c;
  logic [SLOT_W-1:0] sel_c;
  logic [CNT_W-1:0]  count_c;
  logic [CNT_W:0]    lim_chunk;
  logic [CNT_W:0]    pos8;
  logic [CNT_W:0]    issue_lim;
  logic              rd_en;
  logic [MEM_AW-1:0] base;
  logic [MEM_AW-1:0] wr_addr;
  logic [MEM_AW-1:0] rd_addr;
  logic [2:0]        wr_sel;
  logic              crc_ok;
  logic [2:0]        res_code;
  logic [3:0]        snb;
  logic [63:0]       sh_pl;
  logic [63:0]       short_chunk;
  logic [3:0]        len_c;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= 8'h00;
    end else if (cfg_wr_en) begin
      own_id <= cfg_wr_data;
    end
  end

  // frame capture, length clamped to eight
  assign len_c = (in_frame_len > 4'd8) ? 4'd8 : in_frame_len;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_cmd;
      tgt_r <= in_target_id;
      len_r <= len_c;
      pl_r  <= in_payload;
    end
  end

  // frame field decode
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pb[k] = pl_r[8*k +: 8];
    end
  end

  assign is_long    = (cmd_r == CMD_FILL_LONG);
  assign is_proc    = (cmd_r == CMD_PROCESS);
  assign hdr        = is_long ? 4'd2 : 4'd1;
  assign n          = (len_r > hdr) ? 3'(len_r - hdr) : 3'd0;
  assign off16      = is_long ? {pb[0], pb[1]} : {8'h00, pb[0]};
  assign rlen       = {pb[2], pb[3]};
  assign rcrc       = {pb[4], pb[5]};
  assign key_stream = is_proc ? 1'b1 : (off16 != 16'h0000);
  assign key_cnt    = is_proc ? rlen : off16;

  // lowest slot matching streaming flag and count
  always_comb begin
    found_c = 1'b0;
    sel_c   = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (streaming[s] == key_stream && 16'(count[s]) == key_cnt) begin
        found_c = 1'b1;
        sel_c   = SLOT_W'(s);
      end
    end
  end

  assign count_c = count[sel_c];

  // lookup result and fill index
  always_ff @(posedge clk) begin
    if (ctl.lookup) begin
      sel_r   <= sel_c;
      found_r <= found_c;
      plen_r  <= count_c;
    end
    if (ctl.lookup) begin
      fidx <= 3'd0;
    end else if (ctl.fill_wr) begin
      fidx <= fidx + 3'd1;
    end
  end

  // slot table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        streaming[s] <= 1'b0;
        count[s]     <= '0;
      end
    end else if (ctl.fill_commit) begin
      streaming[sel_r] <= 1'b1;
      count[sel_r]     <= count[sel_r] + CNT_W'(n);
    end else if (ctl.slot_free) begin
      streaming[sel_r] <= 1'b0;
      count[sel_r]     <= '0;
    end
  end

  // memory addressing
  assign base    = MEM_AW'(sel_r) * MEM_AW'(MAX_PACKET);
  assign wr_addr = base + MEM_AW'(count[sel_r]) + MEM_AW'(fidx);
  assign rd_addr = base + MEM_AW'(rd_idx);
  assign wr_sel  = hdr[2:0] + fidx;

  assign pos8      = {1'b0, pos} + (CNT_W+1)'(8);
  assign lim_chunk = (pos8 < {1'b0, plen_r}) ? pos8 : {1'b0, plen_r};
  assign issue_lim = ctl.rd_chunk ? lim_chunk : {1'b0, plen_r};
  assign rd_en     = ctl.rd_run && ({1'b0, rd_idx} < issue_lim);

  // packet byte memory
  always_ff @(posedge clk) begin
    if (ctl.fill_wr) begin
      mem[wr_addr] <= pb[wr_sel];
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  // read walk, crc and chunk gathering
  always_ff @(posedge clk) begin
    if (ctl.lookup || ctl.rd_clear) begin
      rd_idx  <= '0;
      got     <= '0;
      pos     <= '0;
      crc     <= 16'h0000;
      chunk_r <= 64'h0;
    end else begin
      if (rd_en) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (rd_vld) begin
        crc                      <= crc16_byte(crc, rd_data);
        chunk_r[got[2:0]*8 +: 8] <= rd_data;
        got                      <= got + CNT_W'(1);
      end
      if (ctl.out_load && ctl.out_chunk) begin
        pos     <= got;
        chunk_r <= 64'h0;
      end
    end
  end

  // verdict of a process frame
  assign crc_ok = (crc == rcrc);

  always_comb begin
    if (!crc_ok) begin
      res_code = ST_CRC_ERR;
    end else if (pb[1] >= MODE_LIMIT) begin
      res_code = ST_BAD_MODE;
    end else begin
      res_code = ST_NOT_DELIVERED;
    end
  end

  // short buffer chunk, bytes two onward
  assign snb   = len_r - 4'd2;
  assign sh_pl = pl_r >> 16;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      short_chunk[8*k +: 8] = (4'(k) < snb) ? sh_pl[8*k +: 8] : 8'h00;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_source_id <= pb[0];
      if (ctl.out_chunk) begin
        out_status      <= ST_DATA;
        out_packet_len  <= 10'(plen_r);
        out_chunk       <= chunk_r;
        out_chunk_bytes <= 4'(got - pos);
        out_last        <= (got == plen_r);
      end else if (cmd_r == CMD_SHORT_BUF) begin
        out_status      <= ST_DATA;
        out_packet_len  <= 10'(snb);
        out_chunk       <= short_chunk;
        out_chunk_bytes <= snb;
        out_last        <= 1'b1;
      end else if (!found_r) begin
        out_status      <= ST_NO_SLOT;
        out_packet_len  <= rlen[9:0];
        out_chunk       <= 64'h0;
        out_chunk_bytes <= 4'd0;
        out_last        <= 1'b1;
      end else begin
        out_status      <= res_code;
        out_packet_len  <= 10'(plen_r);
        out_chunk       <= 64'h0;
        out_chunk_bytes <= 4'd0;
        out_last        <= 1'b1;
      end
    end
  end

  // status toward the controller
  always_comb begin
    st.cmd         = cmd_r;
    st.found       = found_c;
    st.fits        = ({1'b0, count_c} + (CNT_W+1)'(n)) <= (CNT_W+1)'(MAX_PACKET);
    st.short_ok    = (len_r >= 4'd3) && (tgt_r == own_id);
    st.fill_done   = (fidx == n);
    st.crc_done    = (got == plen_r);
    st.deliver     = crc_ok && (pb[1] == MODE_SEND) && (tgt_r == own_id)
                     && (plen_r != '0);
    st.chunk_ready = ({1'b0, got} == lim_chunk);
    st.last_chunk  = (got == plen_r);
    st.out_free    = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

### sv/cpr_ctrl.sv
// ----------------------------------------------------------------------------
// cpr_ctrl
// sequencer for fill, crc check, chunk delivery and single-result frames
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_ctrl import cpr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t st,
  output dp_cmd_t       ctl
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOK = 6'b000010,
    S_FILL = 6'b000100,
    S_CRC  = 6'b001000,
    S_EMIT = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        ctl.lookup = 1'b1;
        case (st.cmd)
          CMD_FILL_SHORT, CMD_FILL_LONG: begin
            state_next = (st.found && st.fits) ? S_FILL : S_IDLE;
          end
          CMD_PROCESS: begin
            state_next = st.found ? S_CRC : S_OUT;
          end
          CMD_SHORT_BUF: begin
            state_next = st.short_ok ? S_OUT : S_IDLE;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_FILL: begin
        if (st.fill_done) begin
          ctl.fill_commit = 1'b1;
          state_next      = S_IDLE;
        end else begin
          ctl.fill_wr = 1'b1;
        end
      end
      S_CRC: begin
        ctl.rd_run = 1'b1;
        if (st.crc_done) begin
          ctl.slot_free = 1'b1;
          if (st.deliver) begin
            ctl.rd_clear = 1'b1;
            state_next   = S_EMIT;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_EMIT: begin
        ctl.rd_run   = 1'b1;
        ctl.rd_chunk = 1'b1;
        if (st.chunk_ready && st.out_free) begin
          ctl.out_load  = 1'b1;
          ctl.out_chunk = 1'b1;
          if (st.last_chunk) begin
            state_next = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### sv/cpr_checker.sv
// ----------------------------------------------------------------------------
// cpr_checker
// port-level checks on the reassembler, attached by bind
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_packet_reassembler_core_defines.svh"

module cpr_checker import cpr_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        frame_valid,
  input wire logic        frame_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [2:0]  res_status,
  input wire logic [63:0] res_chunk,
  input wire logic [3:0]  res_chunk_bytes
);

  // a stalled word holds
  `CPR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_chunk))

  // data words carry bytes, status words carry none
  `CPR_ASSERT_IMPL(a_res_kind, res_valid, (res_status == ST_DATA) == (res_chunk_bytes != 4'd0))

  // never more than eight bytes in a word
  `CPR_ASSERT_IMPL(a_res_bytes, res_valid, res_chunk_bytes <= 4'd8)

  // one frame at a time
  `CPR_ASSERT_NEXT(a_one_frame, frame_valid && frame_ready, !frame_ready)

endmodule

bind can_packet_reassembler_core cpr_checker u_cpr_checker (
  .clk             (clk),
  .rst             (rst),
  .frame_valid     (frame.valid),
  .frame_ready     (frame.ready),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .res_status      (result.status),
  .res_chunk       (result.chunk),
  .res_chunk_bytes (result.chunk_bytes)
);

`default_nettype wire

### verif/can_packet_reassembler_core_tb.sv
// ----------------------------------------------------------------------------
// can_packet_reassembler_core_tb
// self-checking bench: random and directed can frames drive the core while a
// behavioral slot model predicts every result word and a scoreboard checks them
// ----------------------------------------------------------------------------
`default_nettype none

module can_packet_reassembler_core_tb;
  import cpr_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 450;

  // send mode codes beside the delivering one
  localparam logic [7:0] MODE_KEEP  = 8'd0;
  localparam logic [7:0] MODE_ALT   = 8'd2;
  localparam logic [7:0] MODE_WORST = 8'd255;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  target_id;
    logic [3:0]  frame_len;
    logic [63:0] payload;
  } frame_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  source_id;
    logic [9:0]  packet_len;
    logic [63:0] chunk;
    logic [3:0]  chunk_bytes;
    logic        last;
  } word_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  can_frame_if  frame ();
  can_result_if result ();

  can_packet_reassembler_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .frame      (frame.sink),
    .result     (result.source)
  );

  // slot model state
  logic [7:0] node_id;
  bit         slot_busy[NUM_SLOTS];
  int         slot_count[NUM_SLOTS];
  logic [7:0] slot_mem[NUM_SLOTS][MAX_PACKET];

  frame_t frames_pending[$];
  word_t  words_expected[$];

  int  mismatches;
  int  items_queued;
  int  stall_cycles;
  bit  frame_taken;
  bit  calm;
  bit  hold_req;
  bit  hold_seen;
  int  hold_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc_xmodem(input byte_q_t data);
    logic [15:0] c;
    c = 16'h0000;
    foreach (data[i]) begin
      c = c ^ {data[i], 8'h00};
      for (int b = 0; b < 8; b++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  function automatic int find_slot(input bit busy, input int cnt);
    for (int s = 0; s < NUM_SLOTS; s++)
      if (slot_busy[s] == busy && slot_count[s] == cnt) return s;
    return -1;
  endfunction

  task automatic expect_word(input logic [2:0] st, input logic [7:0] src, input int plen,
                             input logic [63:0] c, input int nb, input bit lst);
    word_t w;
    w.status      = st;
    w.source_id   = src;
    w.packet_len  = plen[9:0];
    w.chunk       = c;
    w.chunk_bytes = nb[3:0];
    w.last        = lst;
    words_expected.insert(words_expected.size(), w);
  endtask

  // update slot model for one accepted frame and queue its result words
  task automatic absorb_frame(input frame_t f);
    int         len, hdr, off, n, s, plen, rlen, pos, nb;
    logic [7:0] src, mode;
    logic [15:0] rcrc;
    logic [63:0] c;
    byte_q_t    data;
    len = (f.frame_len > 8) ? 8 : f.frame_len;
    if (f.cmd == CMD_FILL_SHORT || f.cmd == CMD_FILL_LONG) begin
      hdr = (f.cmd == CMD_FILL_LONG) ? 2 : 1;
      off = f.payload[7:0];
      if (f.cmd == CMD_FILL_LONG) off = {f.payload[7:0], f.payload[15:8]};
      n = (len > hdr) ? len - hdr : 0;
      s = find_slot(off != 0, off);
      if (s < 0 || slot_count[s] + n > MAX_PACKET) return;
      for (int i = 0; i < n; i++)
        slot_mem[s][slot_count[s] + i] = f.payload[8*(hdr+i) +: 8];
      slot_count[s] += n;
      slot_busy[s] = 1'b1;
    end else if (f.cmd == CMD_PROCESS) begin
      src  = f.payload[7:0];
      mode = f.payload[15:8];
      rlen = {f.payload[23:16], f.payload[31:24]};
      rcrc = {f.payload[39:32], f.payload[47:40]};
      s = find_slot(1'b1, rlen);
      if (s < 0) begin
        expect_word(ST_NO_SLOT, src, rlen, '0, 0, 1'b1);
        return;
      end
      plen = slot_count[s];
      for (int i = 0; i < plen; i++) data.insert(data.size(), slot_mem[s][i]);
      if (crc_xmodem(data) != rcrc) expect_word(ST_CRC_ERR, src, plen, '0, 0, 1'b1);
      else if (mode >= MODE_LIMIT) expect_word(ST_BAD_MODE, src, plen, '0, 0, 1'b1);
      else if (mode != MODE_SEND || f.target_id != node_id || plen == 0)
        expect_word(ST_NOT_DELIVERED, src, plen, '0, 0, 1'b1);
      else begin
        pos = 0;
        while (pos < plen) begin
          nb = (plen - pos > 8) ? 8 : plen - pos;
          c = '0;
          for (int i = 0; i < nb; i++) c[8*i +: 8] = data[pos + i];
          pos += nb;
          expect_word(ST_DATA, src, plen, c, nb, pos >= plen);
        end
      end
      slot_busy[s]  = 1'b0;
      slot_count[s] = 0;
    end else begin
      if (len < 3 || f.target_id != node_id) return;
      nb = len - 2;
      c = '0;
      for (int i = 0; i < nb; i++) c[8*i +: 8] = f.payload[8*(2+i) +: 8];
      expect_word(ST_DATA, f.payload[7:0], nb, c, nb, 1'b1);
    end
  endtask

  // frame and result side: acceptance, prediction, word checks and watchdog at the rising edge
  always @(posedge clk) begin
    frame_t f;
    word_t  got, want;
    bit     progress;
    if (!rst) begin
      progress = 1'b0;
      if (frame.valid && frame.ready) begin
        f = {frame.cmd, frame.target_id, frame.frame_len, frame.payload};
        absorb_frame(f);
        frame_taken <= 1'b1;
        progress     = 1'b1;
      end
      if (result.valid && result.ready) begin
        progress = 1'b1;
        got = {result.status, result.source_id, result.packet_len, result.chunk,
               result.chunk_bytes, result.last};
        if (words_expected.size() == 0) begin
          $display("%0t unexpected word: expected none, actual %p", $time, got);
          mismatches++;
        end else begin
          want = words_expected.pop_front();
          if (got !== want) begin
            $display("%0t word mismatch: expected %p, actual %p", $time, want, got);
            mismatches++;
          end
        end
      end
      stall_cycles <= progress ? 0 : stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
        $display("%0t watchdog: no progress, %0d words outstanding", $time,
                 words_expected.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // frame driver, changes at the falling edge
  always @(negedge clk) begin
    frame_t f;
    if (!rst && (!frame.valid || frame_taken)) begin
      frame_taken <= 1'b0;
      if (frames_pending.size() > 0 && (calm || $urandom_range(0, 99) >= 26)) begin
        f = frames_pending.pop_front();
        frame.valid     <= 1'b1;
        frame.cmd       <= f.cmd;
        frame.target_id <= f.target_id;
        frame.frame_len <= f.frame_len;
        frame.payload   <= f.payload;
      end else begin
        frame.valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result.ready <= 1'b0;
    end else begin
      result.ready <= calm || ($urandom_range(0, 99) >= 26);
    end
  end

  task automatic add_frame(input logic [1:0] cmd, input logic [7:0] tgt,
                           input logic [3:0] flen, input logic [63:0] p);
    frame_t f;
    f.cmd = cmd;
    f.target_id = tgt;
    f.frame_len = flen;
    f.payload = p;
    frames_pending.insert(frames_pending.size(), f);
    items_queued++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // process frame carrying source, mode, announced length and crc
  task automatic add_process(input logic [7:0] tgt, input logic [7:0] src,
                             input logic [7:0] mode, input logic [15:0] rlen,
                             input logic [15:0] crc);
    logic [63:0] p;
    p = rand64();
    p[47:0] = {crc[7:0], crc[15:8], rlen[7:0], rlen[15:8], mode, src};
    add_frame(CMD_PROCESS, tgt, 4'($urandom_range(0, 15)), p);
  endtask

  // fill frames for an n-byte packet, then the process frame
  task automatic add_packet(input int n, input bit long_off, input logic [7:0] tgt,
                            input logic [7:0] mode, input bit good_crc,
                            input bit overflow_probe);
    byte_q_t    data;
    int         off, per, k, hdr;
    bit         lng;
    logic [63:0] p;
    logic [3:0]  flen;
    logic [15:0] crc;
    for (int i = 0; i < n; i++) data.insert(data.size(), 8'($urandom_range(0, 255)));
    off = 0;
    do begin
      lng = long_off || off > 255;
      hdr = lng ? 2 : 1;
      per = 8 - hdr;
      if (overflow_probe && off + per > n) begin
        // full frame that would run past the buffer end
        p = rand64();
        p[15:0] = {off[7:0], off[15:8]};
        add_frame(CMD_FILL_LONG, 8'($urandom_range(0, 255)), 4'd8, p);
      end
      k = (n - off < per) ? n - off : per;
      if (k > 1 && $urandom_range(0, 3) == 0) k = $urandom_range(1, k);
      p = rand64();
      if (lng) p[15:0] = {off[7:0], off[15:8]};
      else p[7:0] = off[7:0];
      for (int i = 0; i < k; i++) p[8*(hdr+i) +: 8] = data[off + i];
      flen = 4'(k + hdr);
      if (k == per && $urandom_range(0, 2) == 0) flen = 4'($urandom_range(8, 15));
      if (k == 0) flen = 4'($urandom_range(0, hdr));
      add_frame(lng ? CMD_FILL_LONG : CMD_FILL_SHORT, 8'($urandom_range(0, 255)), flen, p);
      off += k;
    end while (off < n);
    crc = crc_xmodem(data);
    if (!good_crc) crc = crc ^ (16'h1 << $urandom_range(0, 15));
    add_process(tgt, 8'($urandom_range(0, 255)), mode, 16'(n), crc);
  endtask

  task automatic add_short_buf(input logic [7:0] tgt, input logic [3:0] flen);
    add_frame(CMD_SHORT_BUF, tgt, flen, rand64());
  endtask

  task automatic add_random_mix(input int count);
    int stop, r, n;
    logic [7:0] mode, tgt;
    stop = items_queued + count;
    while (items_queued < stop) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        r = $urandom_range(0, 9);
        mode = (r < 7) ? MODE_SEND : (r == 7) ? MODE_KEEP : (r == 8) ? MODE_ALT :
               8'($urandom_range(3, 255));
        tgt = ($urandom_range(0, 9) < 8) ? node_id : 8'($urandom_range(0, 255));
        add_packet(n, 1'($urandom_range(0, 1)), tgt, mode, $urandom_range(0, 9) != 0,
                   1'b0);
      end else if (r < 75) begin
        tgt = ($urandom_range(0, 3) != 0) ? node_id : 8'($urandom_range(0, 255));
        add_short_buf(tgt, 4'($urandom_range(0, 15)));
      end else begin
        add_frame(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  4'($urandom_range(0, 15)), rand64());
      end
    end
  endtask

  // wait until every frame went in and every word came out, then let it settle
  task automatic drain();
    while (frames_pending.size() > 0 || frame.valid || words_expected.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_node_id(input logic [7:0] v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    node_id     = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    frame.valid = 1'b0;
    frame.cmd = '0;
    frame.target_id = '0;
    frame.frame_len = '0;
    frame.payload = '0;
    result.ready = 1'b0;
    node_id = '0;
    mismatches = 0;
    items_queued = 0;
    stall_cycles = 0;
    frame_taken = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_busy[s] = 1'b0;
      slot_count[s] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: short buffers, no-slot cases, empty packet, every mode
    write_node_id(8'h00);
    add_short_buf(8'h00, 4'd2);
    add_short_buf(8'h00, 4'd3);
    add_short_buf(8'h00, 4'd8);
    add_short_buf(8'h00, 4'd15);
    add_short_buf(8'h5a, 4'd8);
    add_process(8'h00, 8'hff, MODE_SEND, 16'hffff, 16'h0000);
    add_frame(CMD_FILL_SHORT, 8'h00, 4'd8, 64'hffff_ffff_ffff_ff4d);
    add_frame(CMD_FILL_LONG, 8'h00, 4'd1, 64'h0);
    add_process(8'h00, 8'h00, MODE_SEND, 16'h0000, 16'h0000);
    add_packet(5, 1'b0, 8'h00, MODE_SEND, 1'b1, 1'b0);
    add_packet(3, 1'b1, 8'h00, MODE_SEND, 1'b0, 1'b0);
    add_packet(2, 1'b0, 8'h00, MODE_KEEP, 1'b1, 1'b0);
    add_packet(2, 1'b0, 8'h00, MODE_ALT, 1'b1, 1'b0);
    add_packet(2, 1'b0, 8'h00, MODE_LIMIT, 1'b1, 1'b0);
    add_packet(2, 1'b0, 8'h00, MODE_WORST, 1'b1, 1'b0);
    add_packet(9, 1'b0, 8'h01, MODE_SEND, 1'b1, 1'b0);
    drain();

    // node id at top, with a long result hold-off while frames keep coming
    write_node_id(8'hff);
    hold_req = 1'b1;
    add_random_mix(ITEM_TARGET / 4);
    drain();

    // random node id, no idling on either side
    write_node_id(8'($urandom_range(1, 254)));
    calm = 1'b1;
    add_random_mix(ITEM_TARGET / 4);
    drain();
    calm = 1'b0;

    // full-size packet with an overflowing fill, then more random traffic
    write_node_id(8'($urandom_range(0, 255)));
    add_packet(MAX_PACKET, 1'b1, node_id, MODE_SEND, 1'b1, 1'b1);
    add_random_mix(ITEM_TARGET / 4);
    drain();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+sv
sv/cpr_pkg.sv
sv/cpr_if.sv
sv/cpr_datapath.sv
sv/cpr_ctrl.sv
sv/can_packet_reassembler_core.sv
sv/cpr_checker.sv
verif/can_packet_reassembler_core_tb.sv
